FILE: hw/rtl/ctgc_pkg.sv
// Shared constants, types and helper functions of the circle tile grid collision core.
package ctgc_pkg;

    localparam int GRID_ROWS      = 32;
    localparam int GRID_COLS      = 64;
    localparam int CELL_SIZE_LOG2 = 3;

    localparam int FRAC_BITS  = 4;
    localparam int CELL_SHIFT = CELL_SIZE_LOG2 + FRAC_BITS;
    localparam int CELL_UNITS = 1 << CELL_SHIFT;

    localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int POS_RAW_W = IDX_W + CELL_SHIFT + 1;
    localparam int POS_W     = (POS_RAW_W > 17) ? POS_RAW_W : 17;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 2 * MAG_W;

    localparam int RADIUS_W = 7;
    localparam int FIELD_W  = 11;
    localparam int RSQ_W    = 2 * RADIUS_W;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd48;
    localparam logic [FIELD_W-1:0]  WIDTH_RESET  = 11'd336;
    localparam logic [FIELD_W-1:0]  HEIGHT_RESET = 11'd192;

    localparam logic [CFG_IDX_W-1:0] CFG_BALL_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BOX,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] row,
                                                    input logic [ADDR_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row * ADDR_W'(GRID_COLS));
        return ADDR_W'(base + col);
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [16:0] pos);
        logic [16:0] idx;
        idx = pos >> CELL_SHIFT;
        if (idx > 17'(GRID_COLS - 1))
            return COL_W'(GRID_COLS - 1);
        return idx[COL_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [16:0] pos);
        logic [16:0] idx;
        idx = pos >> CELL_SHIFT;
        if (idx > 17'(GRID_ROWS - 1))
            return ROW_W'(GRID_ROWS - 1);
        return idx[ROW_W-1:0];
    endfunction

    // Distance from a centre coordinate to the closed span of one cell.
    function automatic logic [MAG_W-1:0] nearest_mag(input logic [16:0] c,
                                                     input logic [IDX_W-1:0] idx);
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [POS_W-1:0] cz;
        logic [POS_W-1:0] d;
        lo = POS_W'(idx) << CELL_SHIFT;
        hi = POS_W'(lo + POS_W'(CELL_UNITS));
        cz = POS_W'(c);
        if (cz > hi)
            d = POS_W'(cz - hi);
        else if (cz < lo)
            d = POS_W'(lo - cz);
        else
            d = '0;
        return d[MAG_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/ctgc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ctgc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/circle_tile_grid_collision_core.sv
// Top level of the circle tile grid collision core: wall map, sequencer and result register.
//
// After reset the core clears its wall map one cell a cycle with in_stall held high;
// configuration writes are taken throughout. A write beat is taken in the idle state and
// gives no result. A query beat goes from the box step straight to the drain step when the
// circle leaves the field, and otherwise scans each cell of its bounding box in between.
// The box is scanned through the single read port of the wall map RAM at one cell a cycle,
// followed by a two-stage squaring pipeline. The result beat waits in an output register
// while the next beat is taken.
module circle_tile_grid_collision_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [4:0]                      cell_row,
    input  logic [5:0]                      cell_col,
    input  logic                            wall_bit,
    input  logic signed [15:0]              center_x,
    input  logic signed [15:0]              center_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic                            out_of_field,
    input  logic                            cfg_we,
    input  logic [ctgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctgc_pkg::CFG_W-1:0]      cfg_data
);

    import ctgc_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [FIELD_W-1:0]  width_reg;
    logic [FIELD_W-1:0]  height_reg;

    logic signed [15:0]  cx_reg;
    logic signed [15:0]  cy_reg;
    logic [RSQ_W-1:0]    rsq_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    c0_reg;
    logic [COL_W-1:0]    c1_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    r1_reg;
    logic                oof_reg;
    logic                hit_acc_reg;

    logic                v1_reg;
    logic [MAG_W-1:0]    dx_reg;
    logic [MAG_W-1:0]    dy_reg;
    logic                v2_reg;
    logic                wall2_reg;
    logic [SQ_W-1:0]     dxsq_reg;
    logic [SQ_W-1:0]     dysq_reg;

    logic                out_valid_reg;
    logic                hit_reg;
    logic                oof_out_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic                ram_rdata;

    logic                in_fire;
    logic                wr_in_grid;
    logic                out_load;
    logic                scan_last;

    logic signed [17:0]  x_lo;
    logic signed [17:0]  x_hi;
    logic signed [17:0]  y_lo;
    logic signed [17:0]  y_hi;
    logic signed [17:0]  r_ext;
    logic signed [17:0]  w_ext;
    logic signed [17:0]  h_ext;
    logic                outside;
    logic [SQ_W:0]       dist_sq;

    ctgc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_wall_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_ext   = $signed({11'b0, radius_reg});
    assign w_ext   = $signed({3'b0, width_reg, 4'b0});
    assign h_ext   = $signed({3'b0, height_reg, 4'b0});
    assign x_lo    = 18'(cx_reg) - r_ext;
    assign x_hi    = 18'(cx_reg) + r_ext;
    assign y_lo    = 18'(cy_reg) - r_ext;
    assign y_hi    = 18'(cy_reg) + r_ext;
    assign outside = (x_lo < 18'sd0) || (x_hi >= w_ext) || (y_lo < 18'sd0) || (y_hi >= h_ext);

    assign in_fire    = in_valid && !in_stall;
    assign wr_in_grid = (32'(cell_row) < 32'(GRID_ROWS)) && (32'(cell_col) < 32'(GRID_COLS));
    assign scan_last  = (col_reg == c1_reg) && (row_reg == r1_reg);
    assign dist_sq    = {1'b0, dxsq_reg} + {1'b0, dysq_reg};

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(cell_addr(ADDR_W'(cell_row), ADDR_W'(cell_col)));
        ram_wdata  = wall_bit;
        ram_raddr  = cell_addr(ADDR_W'(row_reg), ADDR_W'(col_reg));
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 1'b0;
                if (clr_cnt_reg == ADDR_W'(MAP_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == CMD_QUERY)
                        state_next = ST_BOX;
                    else
                        ram_we = wr_in_grid;
                end
            end
            ST_BOX:
            begin
                if (outside)
                    state_next = ST_DRAIN;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && (!out_valid_reg || !out_stall))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            radius_reg    <= RADIUS_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= ADDR_W'(clr_cnt_reg + 1'b1);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BALL_RADIUS:  radius_reg <= cfg_data[RADIUS_W-1:0];
                    CFG_FIELD_WIDTH:  width_reg  <= cfg_data[FIELD_W-1:0];
                    CFG_FIELD_HEIGHT: height_reg <= cfg_data[FIELD_W-1:0];
                    default:          ;
                endcase
            end
            v1_reg <= (state_reg == ST_SCAN);
            v2_reg <= v1_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_stall == 1'b0)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && cmd == CMD_QUERY)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
        end
        if (state_reg == ST_BOX)
        begin
            oof_reg     <= outside;
            hit_acc_reg <= 1'b0;
            rsq_reg     <= RSQ_W'(radius_reg * radius_reg);
            c0_reg      <= clamp_col(x_lo[16:0]);
            col_reg     <= clamp_col(x_lo[16:0]);
            c1_reg      <= clamp_col(x_hi[16:0]);
            row_reg     <= clamp_row(y_lo[16:0]);
            r1_reg      <= clamp_row(y_hi[16:0]);
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                if (col_reg == c1_reg)
                begin
                    col_reg <= c0_reg;
                    row_reg <= ROW_W'(row_reg + 1'b1);
                end
                else
                begin
                    col_reg <= COL_W'(col_reg + 1'b1);
                end
            end
            if (v2_reg && wall2_reg && (dist_sq < (SQ_W + 1)'(rsq_reg)))
                hit_acc_reg <= 1'b1;
        end
        dx_reg    <= nearest_mag(cx_reg[15:0] + 17'd0, IDX_W'(col_reg));
        dy_reg    <= nearest_mag(cy_reg[15:0] + 17'd0, IDX_W'(row_reg));
        wall2_reg <= ram_rdata;
        dxsq_reg  <= dx_reg * dx_reg;
        dysq_reg  <= dy_reg * dy_reg;
        if (out_load)
        begin
            hit_reg     <= oof_reg || hit_acc_reg;
            oof_out_reg <= oof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign out_of_field = oof_out_reg;

endmodule

FILE: tb/testbench.sv
// Testbench of the circle tile grid collision core: scoreboard class, stimulus tasks and checks.
module testbench;
    import ctgc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic              cmd;
        logic [4:0]        cell_row;
        logic [5:0]        cell_col;
        logic              wall_bit;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
    } beat_t;

    typedef struct {
        logic hit;
        logic out_of_field;
    } verdict_t;

    function automatic int clip_to(input int v, input int top);
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic longint span_gap(input int c, input int idx);
        int lo;
        int hi;
        int p;
        lo = idx * CELL_UNITS;
        hi = lo + CELL_UNITS;
        p = c;
        if (p > hi)
            p = hi;
        if (p < lo)
            p = lo;
        return longint'(c - p);
    endfunction

    class collision_scoreboard;
        bit wall_map [GRID_ROWS][GRID_COLS];
        bit [RADIUS_W-1:0] radius;
        bit [FIELD_W-1:0] width;
        bit [FIELD_W-1:0] height;
        verdict_t verdicts [$];
        int fails;
        int writes;
        int queries;
        int wall_hits;
        int field_hits;

        function new();
            radius = RADIUS_RESET;
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_BALL_RADIUS:  radius = val[RADIUS_W-1:0];
                CFG_FIELD_WIDTH:  width  = val[FIELD_W-1:0];
                CFG_FIELD_HEIGHT: height = val[FIELD_W-1:0];
                default: ;
            endcase
        endfunction

        function verdict_t classify(input int cx, input int cy);
            verdict_t v;
            int r;
            int w;
            int h;
            int c0;
            int c1;
            int r0;
            int r1;
            longint dx;
            longint dy;
            longint rsq;
            r = radius;
            w = width;
            w = w * 16;
            h = height;
            h = h * 16;
            rsq = longint'(r) * r;
            v.hit = 1'b1;
            v.out_of_field = 1'b1;
            if (cx - r < 0 || cx + r >= w || cy - r < 0 || cy + r >= h)
                return v;
            v.out_of_field = 1'b0;
            c0 = clip_to((cx - r) >>> CELL_SHIFT, GRID_COLS - 1);
            c1 = clip_to((cx + r) >>> CELL_SHIFT, GRID_COLS - 1);
            r0 = clip_to((cy - r) >>> CELL_SHIFT, GRID_ROWS - 1);
            r1 = clip_to((cy + r) >>> CELL_SHIFT, GRID_ROWS - 1);
            for (int row = r0; row <= r1; row++)
                for (int col = c0; col <= c1; col++)
                    if (wall_map[row][col])
                    begin
                        dx = span_gap(cx, col);
                        dy = span_gap(cy, row);
                        if (dx * dx + dy * dy < rsq)
                            return v;
                    end
            v.hit = 1'b0;
            return v;
        endfunction

        function void note_beat(input beat_t b);
            verdict_t v;
            if (b.cmd == CMD_WRITE)
            begin
                writes++;
                if (b.cell_row < GRID_ROWS && b.cell_col < GRID_COLS)
                    wall_map[b.cell_row][b.cell_col] = b.wall_bit;
                return;
            end
            v = classify(b.center_x, b.center_y);
            queries++;
            if (v.out_of_field)
                field_hits++;
            else if (v.hit)
                wall_hits++;
            verdicts.push_back(v);
        endfunction

        function void check_result(input logic got_hit, input logic got_oof);
            verdict_t v;
            if (verdicts.size() == 0)
            begin
                $error("result beat with nothing expected: hit %0d out_of_field %0d",
                       got_hit, got_oof);
                fails++;
                return;
            end
            v = verdicts.pop_front();
            if (got_hit !== v.hit)
            begin
                $error("hit: expected %0d, got %0d", v.hit, got_hit);
                fails++;
            end
            if (got_oof !== v.out_of_field)
            begin
                $error("out_of_field: expected %0d, got %0d", v.out_of_field, got_oof);
                fails++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [4:0]           cell_row;
    logic [5:0]           cell_col;
    logic                 wall_bit;
    logic signed [15:0]   center_x;
    logic signed [15:0]   center_y;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic                 out_of_field;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    collision_scoreboard sb;
    bit quiet;
    bit pressure_req;
    int settings;
    int cycles;

    circle_tile_grid_collision_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .wall_bit     (wall_bit),
        .center_x     (center_x),
        .center_y     (center_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .out_of_field (out_of_field),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int hold_left;
        bit pressure_done;
        hold_left = 0;
        pressure_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(hit, out_of_field);
            if (pressure_req && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 14);
        end
    end

    function automatic beat_t wall_beat(input int row, input int col, input bit wb);
        beat_t b;
        b.cmd      = CMD_WRITE;
        b.cell_row = 5'(row);
        b.cell_col = 6'(col);
        b.wall_bit = wb;
        b.center_x = 16'($urandom);
        b.center_y = 16'($urandom);
        return b;
    endfunction

    function automatic beat_t probe_beat(input int x, input int y);
        beat_t b;
        b.cmd      = CMD_QUERY;
        b.cell_row = 5'($urandom);
        b.cell_col = 6'($urandom);
        b.wall_bit = 1'($urandom);
        b.center_x = 16'(x);
        b.center_y = 16'(y);
        return b;
    endfunction

    task automatic send_beat(input beat_t b);
        int gap;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 14)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= b.cmd;
        cell_row <= b.cell_row;
        cell_col <= b.cell_col;
        wall_bit <= b.wall_bit;
        center_x <= b.center_x;
        center_y <= b.center_y;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_field(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] w,
                                 input logic [CFG_W-1:0] h);
        write_reg(CFG_BALL_RADIUS, r);
        write_reg(CFG_FIELD_WIDTH, w);
        write_reg(CFG_FIELD_HEIGHT, h);
        write_reg(CFG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic run_directed();
        send_beat(wall_beat(0, 0, 1'b1));
        send_beat(wall_beat(GRID_ROWS - 1, GRID_COLS - 1, 1'b1));
        send_beat(wall_beat(0, GRID_COLS - 1, 1'b1));
        send_beat(wall_beat(GRID_ROWS - 1, 0, 1'b0));
        send_beat(wall_beat(5, 5, 1'b1));
        send_beat(probe_beat(-32768, -32768));
        send_beat(probe_beat(32767, 32767));
        send_beat(probe_beat(0, 0));
        send_beat(probe_beat(48, 48));
        send_beat(probe_beat(47, 100));
        send_beat(probe_beat(5327, 100));
        send_beat(probe_beat(5328, 100));
        send_beat(probe_beat(100, 47));
        send_beat(probe_beat(100, 3023));
        send_beat(probe_beat(100, 3024));
        send_beat(probe_beat(592, 700));
        send_beat(probe_beat(593, 700));
        send_beat(probe_beat(798, 798));
        send_beat(probe_beat(802, 802));
        send_beat(wall_beat(5, 5, 1'b0));
        send_beat(probe_beat(593, 700));
    endtask

    task automatic run_random(input int count, input int base_row, input int base_col);
        beat_t b;
        int k;
        int row;
        int col;
        int x;
        int y;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    row = $urandom_range(0, GRID_ROWS - 1);
                    col = $urandom_range(0, GRID_COLS - 1);
                end
                else
                begin
                    row = clip_to(base_row + $urandom_range(0, 5), GRID_ROWS - 1);
                    col = clip_to(base_col + $urandom_range(0, 5), GRID_COLS - 1);
                end
                b = wall_beat(row, col, $urandom_range(0, 99) < 70);
            end
            else if (k < 85)
            begin
                row = base_row + $urandom_range(0, 7);
                col = base_col + $urandom_range(0, 7);
                x = col * CELL_UNITS + $urandom_range(0, 3 * CELL_UNITS - 1) - CELL_UNITS;
                y = row * CELL_UNITS + $urandom_range(0, 3 * CELL_UNITS - 1) - CELL_UNITS;
                b = probe_beat(x, y);
            end
            else if (k < 93)
            begin
                x = $urandom_range(0, sb.width * 16 - 1);
                y = $urandom_range(0, sb.height * 16 - 1);
                b = probe_beat(x, y);
            end
            else
                b = probe_beat($urandom, $urandom);
            send_beat(b);
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 1'b0;
        pressure_req = 1'b0;
        settings = 1;
        rst_n     = 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_WRITE;
        cell_row  <= '0;
        cell_col  <= '0;
        wall_bit  <= 1'b0;
        center_x  <= '0;
        center_y  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BALL_RADIUS;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(120, 2, 2);
        settle();

        program_field(CFG_W'(11'h7FF), 2047, 2047);
        pressure_req = 1'b1;
        run_random(120, 26, 58);
        settle();

        program_field(0, 2047, 2047);
        run_random(80, 10, 10);
        settle();

        program_field(1, 1, 1);
        run_random(60, 0, 0);
        settle();

        program_field(80, 600, 300);
        quiet = 1'b1;
        run_random(120, 12, 30);
        settle();
        quiet = 1'b0;

        program_field(64, 200, 120);
        run_random(120, 4, 8);
        settle();

        $display("Covered %0d map writes and %0d queries over %0d register settings.",
                 sb.writes, sb.queries, settings);
        $display("Queries gave %0d wall hits and %0d out-of-field hits.",
                 sb.wall_hits, sb.field_hits);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
